>>> rtl/fcrg_pkg.sv
// Shared types and constants for the false color ramp generator.
// Depends on nothing.
package fcrg_pkg;

  localparam int unsigned LVL_W  = 8;
  localparam int unsigned COL_W  = 8;
  localparam int unsigned Z_W    = 17;
  localparam int unsigned Q_W    = 32;   // hump product width
  localparam int unsigned SQ_W   = 16;   // isqrt result width
  localparam int unsigned SQ_STEPS = 16; // one result bit per step

  localparam logic [1:0] MODE_SPECTRAL = 2'd0;
  localparam logic [1:0] MODE_GRAY     = 2'd1;
  localparam logic [1:0] MODE_GRAY_REV = 2'd2;

  localparam logic [1:0] REG_SCALE_MODE  = 2'd0;
  localparam logic [1:0] REG_WRAP_RED    = 2'd1;
  localparam logic [1:0] REG_LEVEL_COUNT = 2'd2;

  localparam logic [Z_W-1:0] Z_ONE      = 17'd65536;
  localparam logic [Z_W-1:0] Z_THIRD    = 17'd21844;
  localparam logic [Z_W-1:0] Z_THIRD_HI = 17'd21845;
  localparam logic [Z_W-1:0] Z_THIRD_UP = 17'd21846;
  localparam logic [Z_W-1:0] Z_TWO_3RD  = 17'd43689;
  localparam logic [Z_W-1:0] G_TOP      = 17'd43691;
  localparam logic [Z_W-1:0] B_TOP      = 17'd68813;
  localparam logic [9:0]     RG_GAIN    = 10'd765;
  localparam logic [17:0]    B_GAIN     = 18'd182131;
  localparam logic [7:0]     GRAY_SPAN  = 8'd205;
  localparam logic [7:0]     GRAY_BASE  = 8'd50;

  // one isqrt lane between pipeline stages
  typedef struct packed {
    logic [Q_W-1:0]  rem;
    logic [SQ_W-1:0] root;
    logic            en;
  } sq_lane_t;

  // item context riding alongside the square roots
  typedef struct packed {
    logic [1:0]       mode;
    logic [COL_W-1:0] gray;
  } ctx_t;

  // one step of restoring bit-pair square root
  function automatic sq_lane_t sq_step(input sq_lane_t l, input int unsigned k);
    logic [Q_W+1:0] trial;
    logic [Q_W+1:0] rem_sh;
    sq_lane_t o;
    o = l;
    rem_sh = {2'b00, l.rem};
    trial = ({2'b00, 16'd0, l.root} << (k + 1)) | ({{(Q_W+1){1'b0}}, 1'b1} << (2 * k));
    if (rem_sh >= trial) begin
      o.rem  = Q_W'(rem_sh - trial);
      o.root = l.root | SQ_W'(17'd1 << k);
    end
    return o;
  endfunction

endpackage

>>> rtl/fcrg_if.sv
// Valid/ready channel carrying a packed payload.
// Depends on nothing.
interface fcrg_if #(
  parameter int unsigned W = 8
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/fcrg_cfg_if.sv
// Configuration write channel: register index and data.
// Depends on nothing.
interface fcrg_cfg_if ();
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/fcrg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; used for z = (level<<16)/count and gray ramp.
module fcrg_div #(
  parameter int unsigned NW = 17,
  parameter int unsigned DW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [NW-1:0] q_r   [NW+1];
  logic [DW:0]   rem_r [NW+1];
  logic [NW-1:0] n_r   [NW+1];
  logic [DW-1:0] d_r   [NW+1];

  always_comb begin
    q_r[0]   = '0;
    rem_r[0] = '0;
    n_r[0]   = num;
    d_r[0]   = den;
  end

  // one stage per quotient bit, MSB first
  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW+1:0] sh;
    logic          ge;
    assign sh = {rem_r[i], n_r[i][NW-1-i]};
    assign ge = sh >= {2'b00, d_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? (DW+1)'(sh - {2'b00, d_r[i]}) : sh[DW:0];
        q_r[i+1]   <= q_r[i] | (ge ? (NW'(1) << (NW-1-i)) : '0);
        n_r[i+1]   <= n_r[i];
        d_r[i+1]   <= d_r[i];
      end
    end
  end

  assign quo = q_r[NW];

endmodule

>>> rtl/fcrg_hump.sv
// Hump evaluation: products, pipelined isqrt (two root bits per stage),
// gain multiply and saturation. Depends on fcrg_pkg.
module fcrg_hump
  import fcrg_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [Z_W-1:0]   z,
  input  logic             wrap,
  input  ctx_t             ctx_in,
  output ctx_t             ctx_out,
  output logic [COL_W-1:0] red,
  output logic [COL_W-1:0] green,
  output logic [COL_W-1:0] blue
);

  localparam int unsigned NST = SQ_STEPS / 2;

  // stage A: fold, clip tests, products
  logic [Z_W-1:0] x;
  sq_lane_t       a_r, a_g, a_b;
  ctx_t           a_ctx;
  always_comb begin
    x = (wrap && z > Z_TWO_3RD) ? Z_ONE - z : z;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_r.en   <= x <= Z_THIRD;
      a_r.rem  <= Q_W'((Z_THIRD_HI - x) * (x + Z_THIRD_UP));
      a_r.root <= '0;
      a_g.en   <= z <= Z_TWO_3RD;
      a_g.rem  <= Q_W'((G_TOP - z) * z);
      a_g.root <= '0;
      a_b.en   <= z >= Z_THIRD_UP;
      a_b.rem  <= Q_W'((B_TOP - z) * (z - Z_THIRD_HI));
      a_b.root <= '0;
      a_ctx    <= ctx_in;
    end
  end

  // isqrt stages
  sq_lane_t s_r [NST+1];
  sq_lane_t s_g [NST+1];
  sq_lane_t s_b [NST+1];
  ctx_t     s_c [NST+1];
  always_comb begin
    s_r[0] = a_r;
    s_g[0] = a_g;
    s_b[0] = a_b;
    s_c[0] = a_ctx;
  end
  for (genvar i = 0; i < NST; i++) begin : g_sq
    localparam int unsigned K0 = SQ_STEPS - 1 - 2 * i;
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i+1] <= sq_step(sq_step(s_r[i], K0), K0 - 1);
        s_g[i+1] <= sq_step(sq_step(s_g[i], K0), K0 - 1);
        s_b[i+1] <= sq_step(sq_step(s_b[i], K0), K0 - 1);
        s_c[i+1] <= s_c[i];
      end
    end
  end

  // gain multiply
  logic [25:0] m_r, m_g;
  logic [33:0] m_b;
  logic        e_r, e_g, e_b;
  ctx_t        m_c;
  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= 26'(RG_GAIN * s_r[NST].root);
      m_g <= 26'(RG_GAIN * s_g[NST].root);
      m_b <= 34'(B_GAIN * s_b[NST].root);
      e_r <= s_r[NST].en;
      e_g <= s_g[NST].en;
      e_b <= s_b[NST].en;
      m_c <= s_c[NST];
    end
  end

  // shift, saturate, clip
  always_ff @(posedge clk) begin
    if (en) begin
      red     <= !e_r ? '0 : (m_r[25:24] != 2'b00) ? 8'hFF : m_r[23:16];
      green   <= !e_g ? '0 : (m_g[25:24] != 2'b00) ? 8'hFF : m_g[23:16];
      blue    <= !e_b ? '0 : (m_b[33:32] != 2'b00) ? 8'hFF : m_b[31:24];
      ctx_out <= m_c;
    end
  end

endmodule

>>> rtl/false_color_ramp_generator_unit.sv
// Top level of the false color ramp generator.
// Depends on fcrg_pkg, fcrg_if, fcrg_cfg_if, fcrg_div, fcrg_hump.
//
//  channel | dir | payload
//  --------+-----+---------------------------
//  cfg     | in  | index[1:0], wdata[7:0]
//  in_ch   | in  | level[7:0]
//  out_ch  | out | red, green, blue [7:0] each
//
// One level per clock while the output is not stalled. The pipe holds the
// CW+16-stage divider, a fold/product stage, eight square root stages, a gain
// stage and a saturate stage; a valid bit rides every stage.
// The whole pipe advances when the output register is empty or taken, so a
// stall freezes all stages. Reset (synchronous) clears valid bits and
// restores the registers to spectral mode, no wrap, count 100.
module false_color_ramp_generator_unit
  import fcrg_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = 128
) (
  input logic       clk,
  input logic       rst,
  fcrg_cfg_if.sink  cfg,
  fcrg_if.sink      in_ch,
  fcrg_if.source    out_ch
);

  localparam int unsigned CW  = $clog2(MAX_LEVELS + 1);
  localparam int unsigned LAT = CW + 16 + SQ_STEPS / 2 + 3;

  logic [1:0]       scale_mode;
  logic             wrap_red;
  logic [7:0]       level_count;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode  <= MODE_SPECTRAL;
      wrap_red    <= 1'b0;
      level_count <= 8'd100;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SCALE_MODE:  scale_mode  <= cfg.wdata[1:0];
        REG_WRAP_RED:    wrap_red    <= cfg.wdata[0];
        REG_LEVEL_COUNT: level_count <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic         adv;
  logic [LAT-1:0] vld;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-2:0], in_ch.valid};
  end
  assign out_ch.valid = vld[LAT-1];

  // clamp count and level
  logic [CW-1:0] cnt, lvl;
  always_comb begin
    cnt = (level_count == 8'd0) ? CW'(1)
        : ({{CW{1'b0}}, level_count} > (CW+8)'(MAX_LEVELS)) ? CW'(MAX_LEVELS)
        : CW'(level_count);
    lvl = ({{CW{1'b0}}, in_ch.data[7:0]} > (CW+8)'(cnt)) ? cnt : CW'(in_ch.data[7:0]);
  end

  // gray numerator k*205 and z numerator lvl<<16, divided in parallel
  localparam int unsigned GN = CW + 8;
  localparam int unsigned ZD = CW + 16;
  logic [CW-1:0]  k;
  logic [GN-1:0]  gnum, gq;
  logic [CW+15:0] znum, zq;
  logic [Z_W-1:0] z;
  logic [1:0]     mode_d;
  logic           wrap_d;
  assign k    = (scale_mode == MODE_GRAY_REV) ? cnt - lvl : lvl;
  assign gnum = GN'(k * GRAY_SPAN);
  assign znum = {lvl, 16'd0};

  fcrg_div #(.NW(CW+16), .DW(CW)) u_zdiv (
    .clk, .en(adv), .num(znum), .den(cnt), .quo(zq)
  );
  fcrg_div #(.NW(GN), .DW(CW)) u_gdiv (
    .clk, .en(adv), .num(gnum), .den(cnt), .quo(gq)
  );

  // mode and wrap ride alongside the z divider
  logic [2:0] md [ZD+1];
  assign md[0] = {wrap_red, scale_mode};
  for (genvar i = 0; i < ZD; i++) begin : g_md
    always_ff @(posedge clk) if (adv) md[i+1] <= md[i];
  end
  assign {wrap_d, mode_d} = md[ZD];

  // gray result delayed to match (divider depth difference)
  localparam int unsigned GD = CW + 16 - GN;
  logic [COL_W-1:0] gval;
  logic [COL_W-1:0] gd [GD+1];
  logic [GN:0]      gsum;
  assign gsum  = {1'b0, gq} + (GN+1)'(GRAY_BASE);
  assign gval  = (gsum > (GN+1)'(255)) ? 8'hFF : gsum[7:0];
  assign gd[0] = gval;
  for (genvar i = 0; i < GD; i++) begin : g_gd
    always_ff @(posedge clk) if (adv) gd[i+1] <= gd[i];
  end

  assign z = Z_W'(zq);
  ctx_t ctx_in, ctx_out;
  assign ctx_in = '{mode: mode_d, gray: gd[GD]};
  logic [COL_W-1:0] hr, hg, hb;

  fcrg_hump u_hump (
    .clk, .en(adv), .z, .wrap(wrap_d), .ctx_in, .ctx_out,
    .red(hr), .green(hg), .blue(hb)
  );

  // mode select into output payload
  logic [23:0] pay;
  always_comb begin
    case (ctx_out.mode)
      MODE_SPECTRAL:               pay = {hr, hg, hb};
      MODE_GRAY, MODE_GRAY_REV:    pay = {3{ctx_out.gray}};
      default:                     pay = '0;
    endcase
  end
  assign out_ch.data = pay;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
  a_in_take: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> vld[0])
    else $error("accepted request lost at pipe entry");

endmodule

>>> test/fcrg_test_if.sv
`timescale 1ns / 1ps
// Color record type shared by the bench's predictor and monitor.
// Depends on fcrg_pkg.
package fcrg_test_pkg;
  import fcrg_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } rgb_t;
endpackage

>>> test/false_color_ramp_generator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for false_color_ramp_generator_unit: levels are sent under
// random idling, each color is predicted in fixed point and compared in order.
// Depends on fcrg_pkg, fcrg_test_pkg, fcrg_if, fcrg_cfg_if and the RTL.
module false_color_ramp_generator_unit_test;
  import fcrg_pkg::*;
  import fcrg_test_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int HOLD_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fcrg_cfg_if cfg ();
  fcrg_if #(.W(LVL_W)) in_ch ();
  fcrg_if #(.W(3 * COL_W)) out_ch ();

  false_color_ramp_generator_unit u_dut (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the color registers
  logic [1:0] mode_q = MODE_SPECTRAL;
  logic       wrap_q = 1'b0;
  logic [7:0] count_q = 8'd100;

  logic [LVL_W-1:0] level_queue[$];
  rgb_t             color_queue[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  logic hold_recv;
  bit stim_done = 1'b0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned clip255(longint unsigned v);
    return (v > 255) ? 255 : v;
  endfunction

  // colormap prediction for one level under the current registers
  function automatic rgb_t color_of_level(logic [7:0] lvl_in);
    longint unsigned n, lv, z, x, r, g, b, k, v;
    rgb_t c;
    n = count_q;
    lv = lvl_in;
    r = 0; g = 0; b = 0;
    if (n == 0) n = 1;
    if (n > 128) n = 128;
    if (lv > n) lv = n;
    if (mode_q == MODE_SPECTRAL) begin
      z = (lv << 16) / n;
      x = z;
      if (wrap_q && z > 43689) x = 65536 - z;
      if (x <= 21844) r = clip255((765 * root_floor((21845 - x) * (x + 21846))) >> 16);
      if (z <= 43689) g = clip255((765 * root_floor((43691 - z) * z)) >> 16);
      if (z >= 21846)
        b = clip255((182131 * root_floor((68813 - z) * (z - 21845))) >> 24);
    end else if (mode_q == MODE_GRAY || mode_q == MODE_GRAY_REV) begin
      k = (mode_q == MODE_GRAY) ? lv : n - lv;
      v = clip255(k * 205 / n + 50);
      r = v; g = v; b = v;
    end
    c.red = r[7:0];
    c.green = g[7:0];
    c.blue = b[7:0];
    return c;
  endfunction

  // driver: offers pending levels, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        color_queue.push_back(color_of_level(in_ch.data));
        void'(level_queue.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the request
      end else if (level_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= level_queue[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold, counted here
  assign hold_recv = hold_req && (hold_cnt < HOLD_CYCLES);
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: compare each accepted color with the oldest prediction
  always @(posedge clk) begin
    rgb_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (color_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected color %h", got);
      end else begin
        want = color_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color mismatch: expected r%0d g%0d b%0d got r%0d g%0d b%0d",
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
      end
    end
  end

  // one register write, after which the channel is left idle
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg.index <= idx;
    cfg.wdata <= val;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      REG_SCALE_MODE: mode_q = val[1:0];
      REG_WRAP_RED: wrap_q = val[0];
      REG_LEVEL_COUNT: count_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait for the pipe to drain before touching registers
  task automatic drain();
    while (level_queue.size() != 0 || in_ch.valid || color_queue.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_levels(int n, int maxlvl);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) level_queue.push_back(8'($urandom_range(255)));
      else level_queue.push_back(8'($urandom_range(maxlvl)));
    end
  endtask

  initial begin
    logic [7:0] counts[6];
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.wdata = '0;
    counts = '{8'd1, 8'd128, 8'd3, 8'd100, 8'd0, 8'd255};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, ends, thirds, saturation
    level_queue.push_back(8'd0);
    level_queue.push_back(8'd33);
    level_queue.push_back(8'd34);
    level_queue.push_back(8'd66);
    level_queue.push_back(8'd67);
    level_queue.push_back(8'd100);
    level_queue.push_back(8'd255);
    drain();
    write_reg(REG_LEVEL_COUNT, 8'd3);
    write_reg(REG_WRAP_RED, 8'd1);
    for (int i = 0; i <= 4; i++) level_queue.push_back(8'(i));
    level_queue.push_back(8'd128);
    drain();
    for (int m = 1; m <= 3; m++) begin
      write_reg(REG_SCALE_MODE, 8'(m));
      level_queue.push_back(8'd0);
      level_queue.push_back(8'd2);
      level_queue.push_back(8'd255);
      drain();
    end
    write_reg(REG_SCALE_MODE, 8'hFF); // masked to unused mode
    write_reg(REG_WRAP_RED, 8'hFE);
    write_reg(REG_NONE, 8'h55);        // index beyond the list
    level_queue.push_back(8'd1);
    drain();

    // random phases through the idling patterns and settings
    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      write_reg(REG_SCALE_MODE, 8'($urandom_range(3)));
      write_reg(REG_WRAP_RED, 8'($urandom_range(1)));
      write_reg(REG_LEVEL_COUNT, (p < 6) ? counts[p] : 8'($urandom_range(255)));
      if (p == 5) begin
        // receiver held off long enough for the pipe to fill and stall input
        hold_req = 1'b1;
        send_levels(80, 128);
        wait (hold_cnt == HOLD_CYCLES);
        hold_req = 1'b0;
      end else begin
        send_levels(30, 130);
      end
      drain();
    end
    stim_done = 1'b1;
  end

  // end of run
  initial begin
    wait (stim_done);
    if (mismatches == 0 && color_queue.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
